// ===== design/tlc_pkg.sv =====
// tlc_pkg: shared types and constants of the traffic light controller
// light mode codes, lamp masks, register indexes and default durations
// no dependencies
`default_nettype none

package tlc_pkg;

  localparam int unsigned TLC_COUNT_WIDTH = 16;
  localparam int unsigned REG_WIDTH       = 16;
  localparam int unsigned CFG_IDX_WIDTH   = 3;

  typedef enum logic [3:0] {
    MODE_RED        = 4'd0,
    MODE_GREEN      = 4'd1,
    MODE_YELLOW     = 4'd2,
    MODE_WALK       = 4'd3,
    MODE_WALK_FLASH = 4'd4,
    MODE_RED_FLASH  = 4'd5,
    MODE_NW_RED     = 4'd6,
    MODE_NW_GREEN   = 4'd7,
    MODE_NW_YELLOW  = 4'd8
  } mode_t;

  localparam logic [3:0] LAMP_NONE   = 4'b0000;
  localparam logic [3:0] LAMP_RED    = 4'b0001;
  localparam logic [3:0] LAMP_GREEN  = 4'b0010;
  localparam logic [3:0] LAMP_WALK   = 4'b0100;
  localparam logic [3:0] LAMP_YELLOW = 4'b1000;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RED_TICKS        = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_YELLOW_TICKS     = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WALK_TICKS       = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WALK_FLASH_TICKS = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FLASH_HALF       = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_NO_WALK_TICKS    = 3'd5;

  localparam logic [REG_WIDTH-1:0] RST_RED_TICKS        = 16'd2000;
  localparam logic [REG_WIDTH-1:0] RST_YELLOW_TICKS     = 16'd2000;
  localparam logic [REG_WIDTH-1:0] RST_WALK_TICKS       = 16'd5000;
  localparam logic [REG_WIDTH-1:0] RST_WALK_FLASH_TICKS = 16'd15000;
  localparam logic [REG_WIDTH-1:0] RST_FLASH_HALF       = 16'd500;
  localparam logic [REG_WIDTH-1:0] RST_NO_WALK_TICKS    = 16'd1000;

  typedef struct packed {
    logic [REG_WIDTH-1:0] red_ticks;
    logic [REG_WIDTH-1:0] yellow_ticks;
    logic [REG_WIDTH-1:0] walk_ticks;
    logic [REG_WIDTH-1:0] walk_flash_ticks;
    logic [REG_WIDTH-1:0] flash_half_period;
    logic [REG_WIDTH-1:0] no_walk_phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic button_advance;
    logic button_flash;
    logic button_no_walk;
    logic button_normal;
  } buttons_t;

endpackage

`default_nettype wire

// ===== design/tlc_step.sv =====
// tlc_step: next-state logic for one tick of the traffic light controller
// mode sequencing, saturating phase and flash counters, switch overrides
// depends on tlc_pkg
`default_nettype none

module tlc_step import tlc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = TLC_COUNT_WIDTH
) (
  input  cfg_t                   cfg_i,
  input  buttons_t               btn_i,
  input  mode_t                  mode_i,
  input  logic [COUNT_WIDTH-1:0] tick_i,
  input  logic [COUNT_WIDTH-1:0] flash_i,
  input  logic [3:0]             lamps_i,
  input  logic                   release_wait_i,
  output mode_t                  mode_o,
  output logic [COUNT_WIDTH-1:0] tick_o,
  output logic [COUNT_WIDTH-1:0] flash_o,
  output logic [3:0]             lamps_o,
  output logic                   release_wait_o
);

  localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
    return (x == {COUNT_WIDTH{1'b1}}) ? x : x + 1'b1;
  endfunction

  function automatic logic reached(input logic [COUNT_WIDTH-1:0] cnt,
                                   input logic [REG_WIDTH-1:0]   lim);
    logic [CMP_WIDTH-1:0] cnt_x;
    logic [CMP_WIDTH-1:0] lim_x;
    cnt_x = CMP_WIDTH'(cnt);
    lim_x = CMP_WIDTH'(lim);
    return (cnt_x >= lim_x) || (cnt == {COUNT_WIDTH{1'b1}});
  endfunction

  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [COUNT_WIDTH-1:0] flash_inc;
  logic                   flash_hit;
  logic                   skip_ovr;

  assign tick_inc  = sat_inc(tick_i);
  assign flash_inc = sat_inc(flash_i);
  assign flash_hit = reached(flash_inc, cfg_i.flash_half_period);

  always_comb begin
    mode_o         = mode_i;
    tick_o         = tick_i;
    flash_o        = flash_i;
    lamps_o        = lamps_i;
    release_wait_o = release_wait_i;
    skip_ovr       = 1'b0;

    if (release_wait_i) begin
      if (btn_i.button_advance) begin
        skip_ovr = 1'b1;
      end else begin
        release_wait_o = 1'b0;
        mode_o         = MODE_GREEN;
        tick_o         = '0;
      end
    end else begin
      unique case (mode_i)
        MODE_RED: begin
          lamps_o = LAMP_RED;
          tick_o  = tick_inc;
          if (reached(tick_inc, cfg_i.red_ticks)) begin
            mode_o = MODE_WALK;
            tick_o = '0;
          end
        end
        MODE_GREEN: begin
          lamps_o = LAMP_GREEN;
          tick_o  = tick_inc;
          if (btn_i.button_advance) begin
            mode_o = MODE_YELLOW;
            tick_o = '0;
          end
        end
        MODE_YELLOW: begin
          lamps_o = LAMP_YELLOW;
          tick_o  = tick_inc;
          if (reached(tick_inc, cfg_i.yellow_ticks)) begin
            mode_o = MODE_RED;
            tick_o = '0;
          end
        end
        MODE_WALK: begin
          lamps_o = LAMP_RED | LAMP_WALK;
          tick_o  = tick_inc;
          if (reached(tick_inc, cfg_i.walk_ticks)) begin
            mode_o = MODE_WALK_FLASH;
            tick_o = '0;
          end
        end
        MODE_WALK_FLASH: begin
          tick_o  = tick_inc;
          flash_o = flash_hit ? '0 : flash_inc;
          lamps_o = lamps_i ^ (flash_hit ? LAMP_WALK : LAMP_NONE);
          if (reached(tick_inc, cfg_i.walk_flash_ticks)) begin
            mode_o = MODE_GREEN;
            tick_o = '0;
          end
        end
        MODE_RED_FLASH: begin
          tick_o  = tick_inc;
          flash_o = flash_hit ? '0 : flash_inc;
          lamps_o = (lamps_i & LAMP_RED) ^ (flash_hit ? LAMP_RED : LAMP_NONE);
          if (btn_i.button_advance) begin
            release_wait_o = 1'b1;
            skip_ovr       = 1'b1;
          end
        end
        MODE_NW_RED: begin
          lamps_o = LAMP_RED;
          tick_o  = tick_inc;
          if (reached(tick_inc, cfg_i.no_walk_phase_ticks)) begin
            mode_o = MODE_NW_GREEN;
            tick_o = '0;
          end
        end
        MODE_NW_GREEN: begin
          lamps_o = LAMP_GREEN;
          tick_o  = tick_inc;
          if (reached(tick_inc, cfg_i.no_walk_phase_ticks)) begin
            mode_o = MODE_NW_YELLOW;
            tick_o = '0;
          end
        end
        MODE_NW_YELLOW: begin
          lamps_o = LAMP_YELLOW;
          tick_o  = tick_inc;
          if (reached(tick_inc, cfg_i.no_walk_phase_ticks)) begin
            mode_o = MODE_NW_RED;
            tick_o = '0;
          end
        end
        default: begin
        end
      endcase
    end

    // overrides in rising priority
    if (!skip_ovr) begin
      if (btn_i.button_flash) begin
        mode_o = MODE_RED_FLASH;
        tick_o = '0;
      end
      if (btn_i.button_no_walk) begin
        mode_o = MODE_NW_GREEN;
        tick_o = '0;
      end
      if (btn_i.button_normal) begin
        mode_o = MODE_GREEN;
        tick_o = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/traffic_light_controller.sv =====
// traffic_light_controller: top level, register file, state and result stage
// one tick word in, one lamp/mode word out; depends on tlc_pkg and tlc_step
//
//   channel  | ports                            | word
//   ---------+----------------------------------+----------------------------------
//   in       | in_tvalid in_tready in_tdata[7:0] | switch levels, one tick
//   out      | out_tvalid out_tready out_tdata   | lamps and mode after the tick
//   cfg      | cfg_we cfg_idx cfg_wdata          | duration register write
//
// one tick word per cycle while the output is not stalled; the result appears the cycle after acceptance
// throughput is set by the single state update loop, one word per clock unless out_tready stalls
// rst_n (synchronous) clears the state to green with lamps off, durations to defaults
// while a result waits on out_tready low, in_tready is low and the state holds
`default_nettype none

module traffic_light_controller import tlc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = TLC_COUNT_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // [0] button_advance [1] button_flash [2] button_no_walk [3] button_normal, [7:4] zero
  input  wire logic [7:0]               in_tdata,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // [0] red_on [1] green_on [2] walk_on [3] yellow_on [7:4] mode_code
  output logic [7:0]                    out_tdata,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_idx,
  input  wire logic [REG_WIDTH-1:0]     cfg_wdata
);

  cfg_t                   cfg_r;
  mode_t                  mode_r,  mode_nxt;
  logic [COUNT_WIDTH-1:0] tick_r,  tick_nxt;
  logic [COUNT_WIDTH-1:0] flash_r, flash_nxt;
  logic [3:0]             lamps_r, lamps_nxt;
  logic                   rwait_r, rwait_nxt;
  logic                   out_valid_r;
  buttons_t               btn;
  logic                   in_fire;

  assign btn.button_advance = in_tdata[0];
  assign btn.button_flash   = in_tdata[1];
  assign btn.button_no_walk = in_tdata[2];
  assign btn.button_normal  = in_tdata[3];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {mode_r, lamps_r};

  tlc_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg_i          (cfg_r),
    .btn_i          (btn),
    .mode_i         (mode_r),
    .tick_i         (tick_r),
    .flash_i        (flash_r),
    .lamps_i        (lamps_r),
    .release_wait_i (rwait_r),
    .mode_o         (mode_nxt),
    .tick_o         (tick_nxt),
    .flash_o        (flash_nxt),
    .lamps_o        (lamps_nxt),
    .release_wait_o (rwait_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_ticks           <= RST_RED_TICKS;
      cfg_r.yellow_ticks        <= RST_YELLOW_TICKS;
      cfg_r.walk_ticks          <= RST_WALK_TICKS;
      cfg_r.walk_flash_ticks    <= RST_WALK_FLASH_TICKS;
      cfg_r.flash_half_period   <= RST_FLASH_HALF;
      cfg_r.no_walk_phase_ticks <= RST_NO_WALK_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_RED_TICKS:        cfg_r.red_ticks           <= cfg_wdata;
        CFG_YELLOW_TICKS:     cfg_r.yellow_ticks        <= cfg_wdata;
        CFG_WALK_TICKS:       cfg_r.walk_ticks          <= cfg_wdata;
        CFG_WALK_FLASH_TICKS: cfg_r.walk_flash_ticks    <= cfg_wdata;
        CFG_FLASH_HALF:       cfg_r.flash_half_period   <= cfg_wdata;
        CFG_NO_WALK_TICKS:    cfg_r.no_walk_phase_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_GREEN;
      tick_r      <= '0;
      flash_r     <= '0;
      lamps_r     <= LAMP_NONE;
      rwait_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r  <= mode_nxt;
        tick_r  <= tick_nxt;
        flash_r <= flash_nxt;
        lamps_r <= lamps_nxt;
        rwait_r <= rwait_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tlc_checker.sv =====
// tlc_checker: port-level checks on the traffic light controller
// bound to traffic_light_controller; depends on its port names only
`default_nettype none

module tlc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // a waiting result blocks the input side
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  // every accepted word yields a result next cycle
  a_word_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word produced no result");

  // a stalled result holds its contents
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind traffic_light_controller tlc_checker u_tlc_checker (.*);

`default_nettype wire
